@@ hdl/ljpe_pkg.sv @@
`default_nettype none

package ljpe_pkg;

   // command codes on the request channel
   localparam logic [2:0] CMD_WRITE  = 3'd0;
   localparam logic [2:0] CMD_MOVE   = 3'd1;
   localparam logic [2:0] CMD_INSERT = 3'd2;
   localparam logic [2:0] CMD_DELETE = 3'd3;
   localparam logic [2:0] CMD_TOTAL  = 3'd4;

   // register indexes on the csr port
   localparam logic CSR_ATOMS = 1'b0;
   localparam logic CSR_BOX   = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   // register reset values
   localparam logic [6:0]  ATOMS_RESET = 7'd0;
   localparam logic [22:0] BOX_RESET   = 23'd655360;

   // pair term constants
   localparam logic [49:0]        CUT_SQ    = 50'h0_0009_0000_0000;
   localparam logic [49:0]        NEAR_SQ   = 50'h0_0000_0800_0000;
   localparam logic signed [63:0] NEAR_PAIR = 64'sh0001_0000_0000_0000;
   localparam logic signed [63:0] SHIFT_Q16 = 64'sd359;
   localparam logic [5:0]         DIV_LAST  = 6'd60;

   // accumulator and output limits
   localparam logic signed [63:0] ACC_LIM = 64'sh4000_0000_0000_0000;
   localparam logic signed [63:0] E_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] E_MIN   = -64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
   } pos_type;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_MOVE,
      OP_INSERT,
      OP_DELETE,
      OP_TOTAL,
      OP_IGNORE,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [5:0] idx;
      pos_type    pos;
   } item_type;

   typedef struct packed {
      logic    start;
      pos_type a;
      pos_type b;
   } pair_req_type;

   typedef struct packed {
      logic               done;
      logic               near;
      logic signed [63:0] energy;
   } pair_rsp_type;

   typedef enum logic [2:0] {
      P_IDLE,
      P_SQ,
      P_CHK,
      P_DIV,
      P_MUL,
      P_MST,
      P_FIN
   } pair_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_HOME,
      B_FETCH,
      B_LOAD,
      B_WAIT,
      B_OUTER,
      B_OHOME,
      B_FINAL,
      B_DONE
   } back_state_type;

   // add with clamp to +-2^62
   function automatic logic signed [63:0] acc_add(input logic signed [63:0] acc,
                                                  input logic signed [63:0] p);
      logic signed [63:0] s;
      s = acc + p;
      if (s > ACC_LIM) begin
         s = ACC_LIM;
      end else if (s < -ACC_LIM) begin
         s = -ACC_LIM;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

@@ hdl/lj_pair_energy_delta_engine.sv @@
// Lennard-Jones pair energy engine over a store of atom positions.
// Request channel (req_*): one beat carries a command, an atom index and a
// Q8.16 position; a beat is taken when req_valid is high and req_stall low.
// Result channel (rsp_*): exactly one beat per request, Q32.16 energy and a
// status, in request order; the receiver holds it with rsp_stall.
// CSR port (csr_*): index 0 atoms in use, index 1 box length along x; write
// only while no request is outstanding. csr_ready is always high.
// A two-beat queue sits between the decoder and the pair sequencer, so
// requests are taken while a result waits on a stalled receiver.
// A write, an ignored command or a bad index goes from the queue to the
// sequencer's done state and then the output register to rsp_valid. The pair
// unit works a term as three squares, a 61-step reciprocal and three
// multiplies of four partial products, and stops after the squares when the
// pair is past the cut-off or too near. A move takes two terms against each
// other atom in use, insert one per atom in use, delete one per other atom
// and total one per pair of atoms in use. One request is worked at a time.
// Reset clears the csr registers to their defaults, empties the queue and
// drops rsp_valid; stored positions are undefined until written.
`default_nettype none

module lj_pair_energy_delta_engine #(
   parameter int MAX_ATOMS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_command,
   input  wire logic [5:0]         req_atom_index,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [23:0] req_pos_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [47:0]      rsp_energy,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [22:0]        csr_wdata
);

   localparam int NW = $clog2(MAX_ATOMS + 1);
   localparam int CW = (NW > 7) ? NW : 7;

   logic [6:0]    atoms_ff, atoms_in;
   logic [22:0]   box_ff, box_in;
   logic [CW-1:0] use_w;
   logic [NW-1:0] atoms_n;

   ljpe_pkg::item_type     push_item, q_item;
   ljpe_pkg::pair_req_type pair_req;
   ljpe_pkg::pair_rsp_type pair_rsp;
   logic                   q_push, q_pop, q_full, q_valid;

   // csr registers
   assign csr_ready = 1'b1;

   always_comb begin
      atoms_in = atoms_ff;
      box_in   = box_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ljpe_pkg::CSR_ATOMS: atoms_in = csr_wdata[6:0];
            ljpe_pkg::CSR_BOX:   box_in   = csr_wdata;
            default:             box_in   = box_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atoms_ff <= ljpe_pkg::ATOMS_RESET;
         box_ff   <= ljpe_pkg::BOX_RESET;
      end else begin
         atoms_ff <= atoms_in;
         box_ff   <= box_in;
      end
   end

   // atoms in use, capped at the store depth
   assign use_w   = CW'(atoms_ff);
   assign atoms_n = (use_w > CW'(MAX_ATOMS)) ? NW'(MAX_ATOMS) : NW'(use_w);

   ljpe_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_atom_index (req_atom_index),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .atoms_n        (atoms_n),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   ljpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .valid     (q_valid),
      .item      (q_item),
      .pop       (q_pop)
   );

   ljpe_pair u_pair (
      .clock (clock),
      .reset (reset),
      .box   (box_ff),
      .req   (pair_req),
      .rsp   (pair_rsp)
   );

   ljpe_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .atoms_n    (atoms_n),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .pair_req   (pair_req),
      .pair_rsp   (pair_rsp),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_energy (rsp_energy),
      .rsp_status (rsp_status)
   );

   // checks
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ljpe_pkg::ST_BAD |-> rsp_energy == '0)
      else $error("bad index result carries nonzero energy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ljpe_pkg::ST_OK || rsp_status == ljpe_pkg::ST_SAT
                    || rsp_status == ljpe_pkg::ST_BAD)
      else $error("undefined status code");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("sequencer popped an empty queue");

endmodule

`default_nettype wire

@@ hdl/ljpe_queue.sv @@
`default_nettype none

module ljpe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  ljpe_pkg::item_type      push_item,
   output logic                    full,
   output logic                    valid,
   output ljpe_pkg::item_type      item,
   input  wire logic               pop
);

   ljpe_pkg::item_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign item  = ent_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ hdl/ljpe_front.sv @@
`default_nettype none

module ljpe_front #(
   parameter int MAX_ATOMS = 64
) (
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [2:0]                         req_command,
   input  wire logic [5:0]                         req_atom_index,
   input  wire logic signed [23:0]                 req_pos_x,
   input  wire logic signed [23:0]                 req_pos_y,
   input  wire logic signed [23:0]                 req_pos_z,
   input  wire logic [$clog2(MAX_ATOMS+1)-1:0]     atoms_n,
   input  wire logic                               q_full,
   output logic                                    q_push,
   output ljpe_pkg::item_type                      q_item
);

   localparam int NW = $clog2(MAX_ATOMS + 1);
   localparam int CW = (NW > 7) ? NW : 7;

   logic [CW-1:0] idx_w;
   logic          write_ok;
   logic          use_ok;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // index range checks
   assign idx_w    = CW'(req_atom_index);
   assign write_ok = idx_w < CW'(MAX_ATOMS);
   assign use_ok   = idx_w < CW'(atoms_n);

   // command decode
   always_comb begin
      q_item.idx   = req_atom_index;
      q_item.pos.x = req_pos_x;
      q_item.pos.y = req_pos_y;
      q_item.pos.z = req_pos_z;
      unique case (req_command)
         ljpe_pkg::CMD_WRITE:  q_item.op = write_ok ? ljpe_pkg::OP_WRITE : ljpe_pkg::OP_BAD;
         ljpe_pkg::CMD_MOVE:   q_item.op = use_ok ? ljpe_pkg::OP_MOVE : ljpe_pkg::OP_BAD;
         ljpe_pkg::CMD_INSERT: q_item.op = ljpe_pkg::OP_INSERT;
         ljpe_pkg::CMD_DELETE: q_item.op = use_ok ? ljpe_pkg::OP_DELETE : ljpe_pkg::OP_BAD;
         ljpe_pkg::CMD_TOTAL:  q_item.op = ljpe_pkg::OP_TOTAL;
         default:              q_item.op = ljpe_pkg::OP_IGNORE;
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/ljpe_pair.sv @@
`default_nettype none

module ljpe_pair (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [22:0]          box,
   input  ljpe_pkg::pair_req_type    req,
   output ljpe_pkg::pair_rsp_type    rsp
);

   ljpe_pkg::pair_state_type state_ff, state_in;

   logic [24:0]        ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [49:0]        s_ff, s_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [35:0]        r_ff, r_in;
   logic [33:0]        q_ff, q_in;
   logic [33:0]        u_ff, u_in;
   logic [43:0]        u3_ff, u3_in;
   logic [58:0]        u6_ff, u6_in;
   logic [47:0]        opa_ff, opa_in, opb_ff, opb_in;
   logic [95:0]        prod_ff, prod_in;
   logic [1:0]         mstep_ff, mstep_in;
   logic               done_ff, done_in;
   logic               near_ff, near_in;
   logic signed [63:0] energy_ff, energy_in;

   // distance terms from the request positions
   logic signed [24:0] dx, dy, dz, exa, exb;
   logic [24:0]        adx, ady, adz;
   logic [23:0]        axa, axb;
   logic signed [26:0] wrap;
   logic [26:0]        awrap;
   logic [24:0]        ax_new;

   always_comb begin
      dx  = {req.a.x[23], req.a.x} - {req.b.x[23], req.b.x};
      dy  = {req.a.y[23], req.a.y} - {req.b.y[23], req.b.y};
      dz  = {req.a.z[23], req.a.z} - {req.b.z[23], req.b.z};
      adx = dx[24] ? 25'(-dx) : dx;
      ady = dy[24] ? 25'(-dy) : dy;
      adz = dz[24] ? 25'(-dz) : dz;
      exa = {req.a.x[23], req.a.x};
      exb = {req.b.x[23], req.b.x};
      axa = exa[24] ? 24'(-exa) : exa[23:0];
      axb = exb[24] ? 24'(-exb) : exb[23:0];
      // x-only image: box minus both absolute coordinates
      wrap   = $signed({4'b0, box}) - $signed({3'b0, axa}) - $signed({3'b0, axb});
      awrap  = wrap[26] ? 27'(-wrap) : wrap;
      ax_new = ({1'b0, adx, 1'b0} > {4'b0, box}) ? awrap[24:0] : adx;
   end

   // datapath helpers
   logic [24:0] sq_op;
   logic [49:0] sq;
   logic [36:0] rs;
   logic        ge;
   logic [23:0] ma, mb;
   logic [47:0] pp;
   logic [95:0] pp_sh;
   logic [63:0] r64;
   logic signed [63:0] diff;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_op = ax_ff;
         2'd1:    sq_op = ay_ff;
         default: sq_op = az_ff;
      endcase
      sq = sq_op * sq_op;
      rs = {r_ff, (cnt_ff == 6'd0)};
      ge = rs >= {1'b0, s_ff[35:0]};
      ma = cnt_ff[1] ? opa_ff[47:24] : opa_ff[23:0];
      mb = cnt_ff[0] ? opb_ff[47:24] : opb_ff[23:0];
      pp = ma * mb;
      case (cnt_ff[1:0])
         2'd0:    pp_sh = 96'(pp);
         2'd3:    pp_sh = {pp, 48'd0};
         default: pp_sh = {24'd0, pp, 24'd0};
      endcase
      r64  = prod_ff[91:28];
      diff = $signed({5'b0, u6_ff}) - $signed({20'b0, u3_ff});
   end

   // sequencer: squares, cut-off check, reciprocal, powers, final term
   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      az_in     = az_ff;
      s_in      = s_ff;
      cnt_in    = cnt_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      u_in      = u_ff;
      u3_in     = u3_ff;
      u6_in     = u6_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      prod_in   = prod_ff;
      mstep_in  = mstep_ff;
      done_in   = 1'b0;
      near_in   = near_ff;
      energy_in = energy_ff;
      unique case (state_ff)
         ljpe_pkg::P_IDLE: begin
            if (req.start) begin
               ax_in    = ax_new;
               ay_in    = ady;
               az_in    = adz;
               s_in     = '0;
               cnt_in   = '0;
               state_in = ljpe_pkg::P_SQ;
            end
         end
         ljpe_pkg::P_SQ: begin
            s_in   = s_ff + sq;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd2) begin
               state_in = ljpe_pkg::P_CHK;
            end
         end
         ljpe_pkg::P_CHK: begin
            if (s_ff >= ljpe_pkg::CUT_SQ) begin
               done_in   = 1'b1;
               near_in   = 1'b0;
               energy_in = '0;
               state_in  = ljpe_pkg::P_IDLE;
            end else if (s_ff < ljpe_pkg::NEAR_SQ) begin
               done_in   = 1'b1;
               near_in   = 1'b1;
               energy_in = ljpe_pkg::NEAR_PAIR;
               state_in  = ljpe_pkg::P_IDLE;
            end else begin
               r_in     = '0;
               q_in     = '0;
               cnt_in   = '0;
               state_in = ljpe_pkg::P_DIV;
            end
         end
         ljpe_pkg::P_DIV: begin
            r_in   = ge ? 36'(rs - {1'b0, s_ff[35:0]}) : rs[35:0];
            q_in   = {q_ff[32:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == ljpe_pkg::DIV_LAST) begin
               u_in     = q_in;
               opa_in   = 48'(q_in);
               opb_in   = 48'(q_in);
               prod_in  = '0;
               cnt_in   = '0;
               mstep_in = '0;
               state_in = ljpe_pkg::P_MUL;
            end
         end
         ljpe_pkg::P_MUL: begin
            prod_in = prod_ff + pp_sh;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ljpe_pkg::P_MST;
            end
         end
         ljpe_pkg::P_MST: begin
            prod_in  = '0;
            cnt_in   = '0;
            mstep_in = mstep_ff + 2'd1;
            case (mstep_ff)
               2'd0: begin
                  opa_in   = 48'(r64[38:0]);
                  opb_in   = 48'(u_ff);
                  state_in = ljpe_pkg::P_MUL;
               end
               2'd1: begin
                  u3_in    = r64[43:0];
                  opa_in   = 48'(r64[43:0]);
                  opb_in   = 48'(r64[43:0]);
                  state_in = ljpe_pkg::P_MUL;
               end
               default: begin
                  u6_in    = r64[58:0];
                  state_in = ljpe_pkg::P_FIN;
               end
            endcase
         end
         ljpe_pkg::P_FIN: begin
            done_in   = 1'b1;
            near_in   = 1'b0;
            energy_in = (diff >>> 10) + ljpe_pkg::SHIFT_Q16;
            state_in  = ljpe_pkg::P_IDLE;
         end
         default: state_in = ljpe_pkg::P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ljpe_pkg::P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      az_ff     <= az_in;
      s_ff      <= s_in;
      cnt_ff    <= cnt_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      u_ff      <= u_in;
      u3_ff     <= u3_in;
      u6_ff     <= u6_in;
      opa_ff    <= opa_in;
      opb_ff    <= opb_in;
      prod_ff   <= prod_in;
      mstep_ff  <= mstep_in;
      near_ff   <= near_in;
      energy_ff <= energy_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.near   = near_ff;
   assign rsp.energy = energy_ff;

endmodule

`default_nettype wire

@@ hdl/ljpe_back.sv @@
`default_nettype none

module ljpe_back #(
   parameter int MAX_ATOMS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [$clog2(MAX_ATOMS+1)-1:0]     atoms_n,
   input  wire logic                               q_valid,
   input  ljpe_pkg::item_type                      q_item,
   output logic                                    q_pop,
   output ljpe_pkg::pair_req_type                  pair_req,
   input  ljpe_pkg::pair_rsp_type                  pair_rsp,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [47:0]                      rsp_energy,
   output logic [1:0]                              rsp_status
);

   localparam int NW = $clog2(MAX_ATOMS + 1);
   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

   ljpe_pkg::back_state_type state_ff, state_in;

   ljpe_pkg::pos_type  store_ff [MAX_ATOMS];
   ljpe_pkg::pos_type  rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;

   ljpe_pkg::op_type   op_ff, op_in;
   logic [AW-1:0]      idx_ff, idx_in;
   ljpe_pkg::pos_type  newpos_ff, newpos_in;
   ljpe_pkg::pos_type  home_ff, home_in;
   ljpe_pkg::pos_type  other_ff, other_in;
   logic [NW-1:0]      i_ff, i_in, j_ff, j_in;
   logic signed [63:0] acc_ff, acc_in, old_ff, old_in;
   logic               sat_ff, sat_in;
   logic               phase_ff, phase_in;
   logic signed [47:0] res_energy_ff, res_energy_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_energy_ff, rsp_energy_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               load;
   logic signed [63:0] pterm;
   logic signed [63:0] fin;

   always_comb begin
      pterm = (op_ff == ljpe_pkg::OP_MOVE) ? pair_rsp.energy - old_ff : pair_rsp.energy;
      fin   = (op_ff == ljpe_pkg::OP_DELETE) ? -acc_ff : acc_ff;
   end

   // sequencer over atom pairs
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      newpos_in      = newpos_ff;
      home_in        = home_ff;
      other_in       = other_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      acc_in         = acc_ff;
      old_in         = old_ff;
      sat_in         = sat_ff;
      phase_in       = phase_ff;
      res_energy_in  = res_energy_ff;
      res_status_in  = res_status_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      rd_addr        = j_ff[AW-1:0];
      load           = 1'b0;
      pair_req.start = 1'b0;
      pair_req.a     = newpos_ff;
      pair_req.b     = other_ff;
      unique case (state_ff)
         ljpe_pkg::B_IDLE: begin
            rd_addr = AW'(q_item.idx);
            if (q_valid) begin
               q_pop         = 1'b1;
               op_in         = q_item.op;
               idx_in        = AW'(q_item.idx);
               newpos_in     = q_item.pos;
               acc_in        = '0;
               sat_in        = 1'b0;
               phase_in      = 1'b0;
               i_in          = '0;
               j_in          = '0;
               res_energy_in = '0;
               res_status_in = ljpe_pkg::ST_OK;
               unique case (q_item.op) inside
                  ljpe_pkg::OP_WRITE: begin
                     wr_en    = 1'b1;
                     state_in = ljpe_pkg::B_DONE;
                  end
                  ljpe_pkg::OP_MOVE, ljpe_pkg::OP_DELETE: state_in = ljpe_pkg::B_HOME;
                  ljpe_pkg::OP_INSERT: begin
                     home_in  = q_item.pos;
                     state_in = ljpe_pkg::B_FETCH;
                  end
                  ljpe_pkg::OP_TOTAL: state_in = ljpe_pkg::B_OUTER;
                  ljpe_pkg::OP_BAD: begin
                     res_status_in = ljpe_pkg::ST_BAD;
                     state_in      = ljpe_pkg::B_DONE;
                  end
                  default: state_in = ljpe_pkg::B_DONE;
               endcase
            end
         end
         ljpe_pkg::B_HOME: begin
            home_in  = rd_data_ff;
            state_in = ljpe_pkg::B_FETCH;
         end
         ljpe_pkg::B_FETCH: begin
            if (j_ff >= atoms_n) begin
               if (op_ff == ljpe_pkg::OP_TOTAL) begin
                  i_in     = i_ff + NW'(1);
                  state_in = ljpe_pkg::B_OUTER;
               end else begin
                  state_in = ljpe_pkg::B_FINAL;
               end
            end else if ((op_ff == ljpe_pkg::OP_MOVE || op_ff == ljpe_pkg::OP_DELETE)
                         && j_ff == NW'(idx_ff)) begin
               j_in = j_ff + NW'(1);
            end else begin
               state_in = ljpe_pkg::B_LOAD;
            end
         end
         ljpe_pkg::B_LOAD: begin
            other_in       = rd_data_ff;
            pair_req.start = 1'b1;
            pair_req.a     = home_ff;
            pair_req.b     = rd_data_ff;
            state_in       = ljpe_pkg::B_WAIT;
         end
         ljpe_pkg::B_WAIT: begin
            if (pair_rsp.done) begin
               sat_in = sat_ff | pair_rsp.near;
               if (op_ff == ljpe_pkg::OP_MOVE && !phase_ff) begin
                  // second term at the trial position
                  old_in         = pair_rsp.energy;
                  phase_in       = 1'b1;
                  pair_req.start = 1'b1;
               end else begin
                  acc_in   = ljpe_pkg::acc_add(acc_ff, pterm);
                  phase_in = 1'b0;
                  j_in     = j_ff + NW'(1);
                  state_in = ljpe_pkg::B_FETCH;
               end
            end
         end
         ljpe_pkg::B_OUTER: begin
            rd_addr = i_ff[AW-1:0];
            if (({1'b0, i_ff} + (NW+1)'(1)) >= {1'b0, atoms_n}) begin
               state_in = ljpe_pkg::B_FINAL;
            end else begin
               state_in = ljpe_pkg::B_OHOME;
            end
         end
         ljpe_pkg::B_OHOME: begin
            home_in  = rd_data_ff;
            j_in     = i_ff + NW'(1);
            state_in = ljpe_pkg::B_FETCH;
         end
         ljpe_pkg::B_FINAL: begin
            // clamp to the output range
            if (fin > ljpe_pkg::E_MAX) begin
               res_energy_in = ljpe_pkg::E_MAX[47:0];
               res_status_in = ljpe_pkg::ST_SAT;
            end else if (fin < ljpe_pkg::E_MIN) begin
               res_energy_in = ljpe_pkg::E_MIN[47:0];
               res_status_in = ljpe_pkg::ST_SAT;
            end else begin
               res_energy_in = fin[47:0];
               res_status_in = sat_ff ? ljpe_pkg::ST_SAT : ljpe_pkg::ST_OK;
            end
            state_in = ljpe_pkg::B_DONE;
         end
         ljpe_pkg::B_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ljpe_pkg::B_IDLE;
            end
         end
         default: state_in = ljpe_pkg::B_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = load || (rsp_valid_ff && rsp_stall);
      rsp_energy_in = load ? res_energy_ff : rsp_energy_ff;
      rsp_status_in = load ? res_status_ff : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ljpe_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      newpos_ff     <= newpos_in;
      home_ff       <= home_in;
      other_ff      <= other_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      acc_ff        <= acc_in;
      old_ff        <= old_in;
      sat_ff        <= sat_in;
      phase_ff      <= phase_in;
      res_energy_ff <= res_energy_in;
      res_status_ff <= res_status_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_status_ff <= rsp_status_in;
   end

   // position store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[AW'(q_item.idx)] <= q_item.pos;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_energy = rsp_energy_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

@@ verif/tb_lj_pair_energy_delta_engine.sv @@
`default_nettype none

module tb_lj_pair_energy_delta_engine;
   import ljpe_pkg::*;

   localparam int  ATOM_SLOTS  = 64;
   localparam int  CYCLE_LIMIT = 6000000;
   localparam int  DRAIN_WAIT  = 20;
   localparam int  IDLE_PCT    = 31;
   localparam int  NEAR_SPAN   = 229376;
   localparam logic [47:0] E_TOP = 48'h7FFF_FFFF_FFFF;

   typedef struct packed {
      logic [47:0] energy;
      logic [1:0]  status;
   } energy_result_type;

   typedef struct packed {
      bit          is_csr;
      logic [2:0]  cmd;
      logic [5:0]  idx;
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] z;
      bit          typed;
      logic [47:0] energy;
      logic [1:0]  status;
   } plan_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_command;
   logic [5:0]         req_atom_index;
   logic signed [23:0] req_pos_x;
   logic signed [23:0] req_pos_y;
   logic signed [23:0] req_pos_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [47:0] rsp_energy;
   logic [1:0]         rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [22:0]        csr_wdata;

   lj_pair_energy_delta_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_atom_index (req_atom_index),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_energy     (rsp_energy),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // shadow of the atom store and the registers
   longint      atom_x [ATOM_SLOTS];
   longint      atom_y [ATOM_SLOTS];
   longint      atom_z [ATOM_SLOTS];
   bit          atom_written [ATOM_SLOTS];
   logic [6:0]  atoms_live;
   logic [22:0] box_x;
   bit          near_hit;

   energy_result_type pending_energy [$];
   int  mismatches;
   int  beats_checked;
   int  beats_sent;
   int  cmd_sent [8];
   int  sat_seen;
   int  cycles;
   bit  calm;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < IDLE_PCT);
   end

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // floor(a*b / 2^28)
   function automatic logic [63:0] mul_q28(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[91:28];
   endfunction

   // truncated and shifted lj term between two atoms, q.16
   function automatic longint lj_term(input longint xa, input longint ya, input longint za,
                                      input longint xb, input longint yb, input longint zb);
      longint     dx;
      logic [63:0] ax, ay, az, sq, u1, u2, u3, u6;
      longint     t;
      dx = xa - xb;
      if (2 * mag(dx) > longint'(box_x))
         dx = longint'(box_x) - mag(xa) - mag(xb);
      ax = mag(dx);
      ay = mag(ya - yb);
      az = mag(za - zb);
      sq = ax * ax + ay * ay + az * az;
      if (sq >= (64'd9 << 32))
         return 0;
      if (sq < (64'd1 << 27)) begin
         near_hit = 1'b1;
         return longint'(1) << 48;
      end
      u1 = (64'd1 << 60) / sq;
      u2 = mul_q28(u1, u1);
      u3 = mul_q28(u2, u1);
      u6 = mul_q28(u3, u3);
      t = 4 * (longint'(u6) - longint'(u3));
      return (t >>> 12) + 359;
   endfunction

   function automatic longint clamp_sum(input longint acc, input longint p);
      longint lim;
      lim = longint'(1) << 62;
      acc = acc + p;
      if (acc > lim)
         acc = lim;
      if (acc < -lim)
         acc = -lim;
      return acc;
   endfunction

   // expected result of one command, updates the shadow store
   function automatic energy_result_type energy_of(input logic [2:0] cmd,
                                                   input logic [5:0] idx,
                                                   input pos_type p);
      longint acc, px, py, pz, old_e, new_e;
      int     n;
      logic [1:0] st;
      px = p.x;
      py = p.y;
      pz = p.z;
      n = (atoms_live > ATOM_SLOTS) ? ATOM_SLOTS : atoms_live;
      near_hit = 1'b0;
      acc = 0;
      st = ST_OK;
      case (cmd) inside
         CMD_WRITE: begin
            atom_x[idx] = px;
            atom_y[idx] = py;
            atom_z[idx] = pz;
            atom_written[idx] = 1'b1;
         end
         CMD_MOVE, CMD_DELETE: begin
            if (idx >= n) begin
               st = ST_BAD;
            end else begin
               for (int i = 0; i < n; i++) begin
                  if (i != idx) begin
                     old_e = lj_term(atom_x[idx], atom_y[idx], atom_z[idx],
                                     atom_x[i], atom_y[i], atom_z[i]);
                     if (cmd == CMD_MOVE) begin
                        new_e = lj_term(px, py, pz, atom_x[i], atom_y[i], atom_z[i]);
                        acc = clamp_sum(acc, new_e - old_e);
                     end else begin
                        acc = clamp_sum(acc, old_e);
                     end
                  end
               end
               if (cmd == CMD_DELETE)
                  acc = -acc;
            end
         end
         CMD_INSERT: begin
            for (int i = 0; i < n; i++)
               acc = clamp_sum(acc, lj_term(px, py, pz, atom_x[i], atom_y[i], atom_z[i]));
         end
         CMD_TOTAL: begin
            for (int i = 0; i < n; i++)
               for (int j = i + 1; j < n; j++)
                  acc = clamp_sum(acc, lj_term(atom_x[i], atom_y[i], atom_z[i],
                                               atom_x[j], atom_y[j], atom_z[j]));
         end
         default: ;
      endcase
      if (st == ST_OK) begin
         if (acc > E_MAX) begin
            acc = E_MAX;
            near_hit = 1'b1;
         end else if (acc < E_MIN) begin
            acc = E_MIN;
            near_hit = 1'b1;
         end
         if (near_hit)
            st = ST_SAT;
      end else begin
         acc = 0;
      end
      return '{energy: acc[47:0], status: st};
   endfunction

   // one request beat, with random gaps ahead of it
   task automatic send_cmd(input logic [2:0] cmd, input logic [5:0] idx, input pos_type p,
                           input bit typed, input logic [47:0] t_energy,
                           input logic [1:0] t_status);
      energy_result_type want;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_atom_index <= idx;
      req_pos_x      <= p.x;
      req_pos_y      <= p.y;
      req_pos_z      <= p.z;
      do @(posedge clock); while (req_stall);
      want = energy_of(cmd, idx, p);
      if (typed)
         want = '{energy: t_energy, status: t_status};
      pending_energy.push_back(want);
      beats_sent++;
      cmd_sent[cmd]++;
   endtask

   // register write once every result is back
   task automatic write_csr(input logic idx, input logic [22:0] val);
      req_valid <= 1'b0;
      while (pending_energy.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ATOMS)
         atoms_live = val[6:0];
      else
         box_x = val;
   endtask

   function automatic pos_type pick_pos();
      pos_type p;
      int      r, j, n;
      r = $urandom_range(99);
      n = (atoms_live > ATOM_SLOTS) ? ATOM_SLOTS : atoms_live;
      if (r < 12 && n > 0) begin
         // close to an existing atom
         j = $urandom_range(n - 1);
         p.x = 24'(atom_x[j] + $urandom_range(4000) - 2000);
         p.y = 24'(atom_y[j] + $urandom_range(4000) - 2000);
         p.z = 24'(atom_z[j] + $urandom_range(4000) - 2000);
      end else if (r < 80) begin
         p.x = 24'(int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN);
         p.y = 24'(int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN);
         p.z = 24'(int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN);
      end else begin
         p.x = 24'($urandom);
         p.y = 24'($urandom);
         p.z = 24'($urandom);
      end
      return p;
   endfunction

   // every atom in use gets a position before any sum reads it
   task automatic fill_store();
      for (int i = 0; i < atoms_live && i < ATOM_SLOTS; i++)
         if (!atom_written[i])
            send_cmd(CMD_WRITE, 6'(i), pick_pos(), 1'b0, '0, ST_OK);
   endtask

   task automatic random_beats(input int count, input bit with_total);
      logic [2:0] cmd;
      logic [5:0] idx;
      int         r, n;
      n = (atoms_live > ATOM_SLOTS) ? ATOM_SLOTS : atoms_live;
      fill_store();
      for (int k = 0; k < count; k++) begin
         calm = (beats_sent >= 520 && beats_sent < 720);
         r = $urandom_range(99);
         if (r < 30)
            cmd = CMD_WRITE;
         else if (r < 55)
            cmd = CMD_MOVE;
         else if (r < 68)
            cmd = CMD_INSERT;
         else if (r < 82)
            cmd = CMD_DELETE;
         else if (r < 90)
            cmd = with_total ? CMD_TOTAL : CMD_MOVE;
         else
            cmd = 3'(CMD_TOTAL + $urandom_range(1, 3));
         if ((cmd == CMD_MOVE || cmd == CMD_DELETE) && n > 0 && $urandom_range(9) != 0)
            idx = 6'($urandom_range(n - 1));
         else
            idx = 6'($urandom);
         send_cmd(cmd, idx, pick_pos(), 1'b0, '0, ST_OK);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      energy_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_energy.size() == 0) begin
            $error("result beat with nothing expected: energy %0d status %0d",
                   rsp_energy, rsp_status);
            mismatches++;
         end else begin
            want = pending_energy.pop_front();
            beats_checked++;
            if (rsp_status == ST_SAT)
               sat_seen++;
            if (rsp_energy !== want.energy) begin
               $error("energy: expected %0d, got %0d", $signed(want.energy), rsp_energy);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   plan_row_type plan [20];

   localparam logic [23:0] P_MAX = 24'h7F_FFFF;
   localparam logic [23:0] P_MIN = 24'h80_0000;
   localparam logic [23:0] P_ONE = 24'd65536;

   // stimulus
   initial begin
      pos_type p;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_WRITE;
      req_atom_index = '0;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_pos_z      = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_ATOMS;
      csr_wdata      = '0;
      mismatches     = 0;
      beats_checked  = 0;
      beats_sent     = 0;
      sat_seen       = 0;
      calm           = 1'b0;
      atoms_live     = ATOMS_RESET;
      box_x          = BOX_RESET;
      foreach (cmd_sent[i]) cmd_sent[i] = 0;
      foreach (atom_written[i]) atom_written[i] = 1'b0;

      plan = '{
         // empty store: writes, bad indexes, empty sums, spare codes
         '{0, CMD_WRITE,  6'd0,  24'd0, 24'd0, 24'd0, 1, 48'd0, ST_OK},
         '{0, CMD_WRITE,  6'd63, P_MAX, P_MAX, P_MAX, 1, 48'd0, ST_OK},
         '{0, CMD_WRITE,  6'd62, P_MIN, P_MIN, P_MIN, 1, 48'd0, ST_OK},
         '{0, CMD_MOVE,   6'd0,  P_ONE, 24'd0, 24'd0, 1, 48'd0, ST_BAD},
         '{0, CMD_DELETE, 6'd63, 24'd0, 24'd0, 24'd0, 1, 48'd0, ST_BAD},
         '{0, CMD_INSERT, 6'd63, 24'd0, 24'd0, 24'd0, 1, 48'd0, ST_OK},
         '{0, CMD_TOTAL,  6'd0,  24'd0, 24'd0, 24'd0, 1, 48'd0, ST_OK},
         '{0, CMD_TOTAL + 3'd1, 6'd5,  P_MAX, 24'd0, P_MIN, 1, 48'd0, ST_OK},
         '{0, CMD_TOTAL + 3'd2, 6'd42, 24'd0, P_MIN, 24'd0, 1, 48'd0, ST_OK},
         '{0, CMD_TOTAL + 3'd3, 6'd63, P_MIN, P_MAX, P_MAX, 1, 48'd0, ST_OK},
         // two atoms in use
         '{1, CMD_WRITE,  6'd2,  24'd0, 24'd0, 24'd0, 0, 48'd0, ST_OK},
         '{0, CMD_WRITE,  6'd1,  P_ONE, 24'd0, 24'd0, 1, 48'd0, ST_OK},
         '{0, CMD_INSERT, 6'd0,  24'd0, 24'd0, 24'd0, 1, E_TOP, ST_SAT},
         '{0, CMD_MOVE,   6'd2,  24'd0, 24'd0, 24'd0, 1, 48'd0, ST_BAD},
         '{0, CMD_INSERT, 6'd9,  P_MAX, P_MAX, P_MAX, 1, 48'd0, ST_OK},
         '{0, CMD_TOTAL,  6'd0,  24'd0, 24'd0, 24'd0, 0, 48'd0, ST_OK},
         '{0, CMD_MOVE,   6'd0,  24'd0, 24'd131072, 24'd0, 0, 48'd0, ST_OK},
         '{0, CMD_MOVE,   6'd1,  24'd65000, 24'd0, 24'd0, 0, 48'd0, ST_OK},
         '{0, CMD_DELETE, 6'd1,  24'd0, 24'd0, 24'd0, 0, 48'd0, ST_OK},
         '{0, CMD_INSERT, 6'd0,  24'd98304, 24'd98304, 24'd0, 0, 48'd0, ST_OK}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            write_csr(CSR_ATOMS, 23'(plan[i].idx));
         end else begin
            p.x = plan[i].x;
            p.y = plan[i].y;
            p.z = plan[i].z;
            send_cmd(plan[i].cmd, plan[i].idx, p, plan[i].typed,
                     plan[i].energy, plan[i].status);
         end
      end

      // random phases over register settings, small atom counts mostly
      write_csr(CSR_ATOMS, 23'd0);
      random_beats(180, 1'b1);
      write_csr(CSR_ATOMS, 23'd1);
      write_csr(CSR_BOX, 23'd0);
      random_beats(100, 1'b1);
      write_csr(CSR_ATOMS, 23'd2);
      write_csr(CSR_BOX, 23'h7F_FFFF);
      random_beats(200, 1'b1);
      write_csr(CSR_ATOMS, 23'd4);
      write_csr(CSR_BOX, BOX_RESET);
      random_beats(350, 1'b1);
      write_csr(CSR_ATOMS, 23'd6);
      write_csr(CSR_BOX, 23'd400000);
      random_beats(330, 1'b1);
      write_csr(CSR_ATOMS, 23'd10);
      write_csr(CSR_BOX, 23'd1000000);
      random_beats(240, 1'b1);

      // full store, a single total pass
      write_csr(CSR_ATOMS, 23'd64);
      write_csr(CSR_BOX, BOX_RESET);
      random_beats(20, 1'b0);
      send_cmd(CMD_TOTAL, 6'd0, '0, 1'b0, '0, ST_OK);
      req_valid <= 1'b0;

      // drain
      while (pending_energy.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d requests (write %0d move %0d insert %0d delete %0d total %0d)",
               beats_sent, cmd_sent[CMD_WRITE], cmd_sent[CMD_MOVE], cmd_sent[CMD_INSERT],
               cmd_sent[CMD_DELETE], cmd_sent[CMD_TOTAL]);
      $display("checked %0d results, %0d saturated, atom counts 0 to 64, box 0 to max",
               beats_checked, sat_seen);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/ljpe_pkg.sv
hdl/ljpe_queue.sv
hdl/ljpe_front.sv
hdl/ljpe_pair.sv
hdl/ljpe_back.sv
hdl/lj_pair_energy_delta_engine.sv
verif/tb_lj_pair_energy_delta_engine.sv
